### hdl/rgbmorph_pkg.sv
// Shared types, constants and helper functions for the RGB morphology filter.
`timescale 1ns / 1ps
`default_nettype none

package rgbmorph_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned ROW_W       = 11;
    localparam int unsigned SIZE_W      = 12;
    localparam int unsigned MASK_SIDE   = 7;
    localparam int unsigned MASK_CENTER = 3;
    localparam int unsigned MASK_W      = MASK_SIDE * MASK_SIDE;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = MASK_W;

    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 12'd2048;

    localparam logic              RST_DILATE_MODE  = 1'b0;
    localparam logic [MASK_W-1:0] RST_ELEMENT_MASK = 49'd37331586227976;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 12'd480;

    localparam logic [PIX_W-1:0] ERODE_INIT  = 8'd255;
    localparam logic [PIX_W-1:0] DILATE_INIT = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DILATE_MODE  = 2'd0,
        CFG_ELEMENT_MASK = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic             frame_start;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } in_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_done;
    } out_beat_t;

    function automatic logic [PIX_W-1:0] pick(logic [PIX_W-1:0] acc, logic [PIX_W-1:0] v,
                                              logic take_max);
        if (take_max) begin
            return (v > acc) ? v : acc;
        end
        return (v < acc) ? v : acc;
    endfunction

    function automatic rgb_t pick_rgb(rgb_t acc, rgb_t v, logic take_max);
        rgb_t r;
        r.red   = pick(acc.red, v.red, take_max);
        r.green = pick(acc.green, v.green, take_max);
        r.blue  = pick(acc.blue, v.blue, take_max);
        return r;
    endfunction

    function automatic rgb_t init_rgb(logic take_max);
        rgb_t r;
        r.red   = take_max ? DILATE_INIT : ERODE_INIT;
        r.green = r.red;
        r.blue  = r.red;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rgbmorph_line_buf.sv
// Line store RAM with read-modify-write of one column word per pixel and forwarding.
`timescale 1ns / 1ps
`default_nettype none

module rgbmorph_line_buf #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned WINDOW    = 7
) (
    input  wire                                       aclk,
    input  wire                                       adv,
    input  wire                                       rd_valid,
    input  wire  [$clog2(MAX_WIDTH)-1:0]              rd_idx,
    input  rgbmorph_pkg::rgb_t                        pix_in,
    input  wire                                       b_valid,
    output rgbmorph_pkg::rgb_t [WINDOW-1:0]           col_vec
);

    localparam int unsigned ROWS = WINDOW - 1;
    localparam int unsigned CW   = $clog2(MAX_WIDTH);

    rgbmorph_pkg::rgb_t [ROWS-1:0] line_mem [MAX_WIDTH];

    rgbmorph_pkg::rgb_t [ROWS-1:0] rd_word_reg;
    rgbmorph_pkg::rgb_t [ROWS-1:0] wr_word_reg;
    rgbmorph_pkg::rgb_t            pix_b_reg;
    logic [CW-1:0]                 idx_b_reg;
    logic                          fwd_reg;

    rgbmorph_pkg::rgb_t [ROWS-1:0] old_word;
    rgbmorph_pkg::rgb_t [ROWS-1:0] new_word;

    always_comb begin
        old_word    = fwd_reg ? wr_word_reg : rd_word_reg;
        new_word[0] = pix_b_reg;
        for (int k = 1; k < ROWS; k++) begin
            new_word[k] = old_word[k-1];
        end
        col_vec[WINDOW-1] = pix_b_reg;
        for (int k = 0; k < ROWS; k++) begin
            col_vec[WINDOW-2-k] = old_word[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && b_valid) begin
            line_mem[idx_b_reg] <= new_word;
        end
        if (adv && rd_valid) begin
            rd_word_reg <= line_mem[rd_idx];
            wr_word_reg <= new_word;
            fwd_reg     <= b_valid && (idx_b_reg == rd_idx);
            idx_b_reg   <= rd_idx;
            pix_b_reg   <= pix_in;
        end
    end

endmodule

`default_nettype wire

### hdl/rgbmorph_window_reduce.sv
// Pixel window registers and two-stage masked min/max reduction.
`timescale 1ns / 1ps
`default_nettype none

module rgbmorph_window_reduce #(
    parameter int unsigned WINDOW = 7
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       adv,
    input  wire                                       shift_en,
    input  rgbmorph_pkg::rgb_t [WINDOW-1:0]           col_vec,
    input  wire                                       res_valid,
    input  wire                                       res_last,
    input  wire                                       dilate_mode,
    input  wire  [rgbmorph_pkg::MASK_W-1:0]           element_mask,
    output logic                                      red_valid,
    output rgbmorph_pkg::out_beat_t                   red_beat
);

    localparam int unsigned HALF = WINDOW / 2;

    rgbmorph_pkg::rgb_t [WINDOW-1:0] win_reg [WINDOW];
    rgbmorph_pkg::rgb_t              part_reg [WINDOW];
    rgbmorph_pkg::rgb_t              part_next [WINDOW];
    logic [WINDOW-1:0]               en [WINDOW];

    logic p2_valid_reg;
    logic p2_last_reg;
    logic p3_valid_reg;
    logic p3_last_reg;

    for (genvar a = 0; a < WINDOW; a++) begin : g_col
        for (genvar b = 0; b < WINDOW; b++) begin : g_row
            localparam int BIT = (a - HALF + rgbmorph_pkg::MASK_CENTER) * rgbmorph_pkg::MASK_SIDE
                               + (b - HALF + rgbmorph_pkg::MASK_CENTER);
            assign en[a][b] = element_mask[BIT];
        end
    end

    always_comb begin
        rgbmorph_pkg::rgb_t acc;
        for (int a = 0; a < WINDOW; a++) begin
            acc = rgbmorph_pkg::init_rgb(dilate_mode);
            for (int b = 0; b < WINDOW; b++) begin
                if (en[a][b]) begin
                    acc = rgbmorph_pkg::pick_rgb(acc, win_reg[a][b], dilate_mode);
                end
            end
            part_next[a] = acc;
        end
    end

    always_comb begin
        rgbmorph_pkg::rgb_t acc;
        acc = rgbmorph_pkg::init_rgb(dilate_mode);
        for (int a = 0; a < WINDOW; a++) begin
            acc = rgbmorph_pkg::pick_rgb(acc, part_reg[a], dilate_mode);
        end
        red_beat.red_out    = acc.red;
        red_beat.green_out  = acc.green;
        red_beat.blue_out   = acc.blue;
        red_beat.frame_done = p3_last_reg;
    end

    assign red_valid = p3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= res_valid;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (shift_en) begin
                for (int a = 0; a < WINDOW - 1; a++) begin
                    win_reg[a] <= win_reg[a+1];
                end
                win_reg[WINDOW-1] <= col_vec;
            end
            p2_last_reg <= res_last;
            p3_last_reg <= p2_last_reg;
            for (int a = 0; a < WINDOW; a++) begin
                part_reg[a] <= part_next[a];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/rgb_morph_erode_dilate_7x7.sv
// Top level of the streaming RGB erosion / dilation filter.
//
//  port group     dir  handshake              payload
//  s_*            in   s_valid / s_ready      s_data  (in_beat_t)
//  m_*            out  m_valid / m_ready      m_data  (out_beat_t)
//  cfg_*          in   cfg_wr_en              cfg_index, cfg_wdata
//
//  One pixel per cycle while s_ready is high; m_valid follows a completed window through p1, p2, p3 and out.
//  The line RAM takes one column read and one write-back per cycle unless stalled; a read that hits the
//  column written in the same cycle takes the forwarded word.
//  Reset clears position counters and pipeline valids and loads default config; line RAM is not cleared.
//  s_ready drops only while m_data is held and a result reaches the output register.
`timescale 1ns / 1ps
`default_nettype none

module rgb_morph_erode_dilate_7x7 #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned WINDOW    = 7
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       s_valid,
    output logic                                      s_ready,
    input  rgbmorph_pkg::in_beat_t                    s_data,
    output logic                                      m_valid,
    input  wire                                       m_ready,
    output rgbmorph_pkg::out_beat_t                   m_data,
    input  wire                                       cfg_wr_en,
    input  wire  [rgbmorph_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [rgbmorph_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = (CW + 1 > rgbmorph_pkg::SIZE_W) ? CW + 1 : rgbmorph_pkg::SIZE_W;
    localparam int unsigned SW = rgbmorph_pkg::SIZE_W;
    localparam int unsigned RW = rgbmorph_pkg::ROW_W;

    logic                            dilate_mode_reg;
    logic [rgbmorph_pkg::MASK_W-1:0] element_mask_reg;
    logic [SW-1:0]                   frame_width_reg;
    logic [SW-1:0]                   frame_height_reg;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic p1_valid_reg;
    logic p1_int_reg;
    logic p1_last_reg;

    logic                    out_valid_reg;
    rgbmorph_pkg::out_beat_t out_beat_reg;

    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;
    logic [WW-1:0] fw;
    logic [WW-1:0] w_clamp;
    logic [WW-1:0] w_m1;
    logic [WW-1:0] col_ext;
    logic [SW-1:0] h_clamp;
    logic [SW-1:0] h_m1;
    logic [SW-1:0] row_ext;
    logic          is_int;
    logic          is_last;
    logic          adv;
    logic          accept;

    rgbmorph_pkg::rgb_t                pix_in;
    rgbmorph_pkg::rgb_t [WINDOW-1:0]   col_vec;
    logic                              red_valid;
    rgbmorph_pkg::out_beat_t           red_beat;

    assign adv     = !(out_valid_reg && !m_ready && red_valid);
    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

    assign pix_in.red   = s_data.red_in;
    assign pix_in.green = s_data.green_in;
    assign pix_in.blue  = s_data.blue_in;

    always_comb begin
        col_eff = s_data.frame_start ? '0 : col_reg;
        row_eff = s_data.frame_start ? '0 : row_reg;

        fw = WW'(frame_width_reg);
        if (fw < WW'(WINDOW)) begin
            w_clamp = WW'(WINDOW);
        end else if (fw > WW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = fw;
        end
        w_m1 = w_clamp - WW'(1);

        if (frame_height_reg < SW'(WINDOW)) begin
            h_clamp = SW'(WINDOW);
        end else if (frame_height_reg > rgbmorph_pkg::MAX_HEIGHT) begin
            h_clamp = rgbmorph_pkg::MAX_HEIGHT;
        end else begin
            h_clamp = frame_height_reg;
        end
        h_m1 = h_clamp - SW'(1);

        col_ext = WW'(col_eff);
        row_ext = SW'(row_eff);
        is_int  = (col_ext >= WW'(WINDOW - 1)) && (row_ext >= SW'(WINDOW - 1)) &&
                  (col_ext < w_clamp) && (row_ext < h_clamp);
        is_last = (col_ext == w_m1) && (row_ext == h_m1);

        if (col_ext >= w_m1) begin
            col_next = '0;
            row_next = (row_ext == h_m1) ? '0 : row_eff + RW'(1);
        end else begin
            col_next = col_eff + CW'(1);
            row_next = row_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dilate_mode_reg  <= rgbmorph_pkg::RST_DILATE_MODE;
            element_mask_reg <= rgbmorph_pkg::RST_ELEMENT_MASK;
            frame_width_reg  <= rgbmorph_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= rgbmorph_pkg::RST_FRAME_HEIGHT;
        end else if (cfg_wr_en) begin
            case (rgbmorph_pkg::cfg_index_t'(cfg_index))
                rgbmorph_pkg::CFG_DILATE_MODE: begin
                    dilate_mode_reg <= cfg_wdata[0];
                end
                rgbmorph_pkg::CFG_ELEMENT_MASK: begin
                    element_mask_reg <= cfg_wdata;
                end
                rgbmorph_pkg::CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wdata[SW-1:0];
                end
                rgbmorph_pkg::CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wdata[SW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv) begin
                p1_valid_reg <= s_valid;
            end
            if (adv && red_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_int_reg  <= is_int;
            p1_last_reg <= is_last;
        end
        if (adv && red_valid) begin
            out_beat_reg <= red_beat;
        end
    end

    rgbmorph_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .WINDOW    (WINDOW)
    ) u_line_buf (
        .aclk     (aclk),
        .adv      (adv),
        .rd_valid (s_valid),
        .rd_idx   (col_eff),
        .pix_in   (pix_in),
        .b_valid  (p1_valid_reg),
        .col_vec  (col_vec)
    );

    rgbmorph_window_reduce #(
        .WINDOW (WINDOW)
    ) u_window_reduce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .shift_en     (p1_valid_reg),
        .col_vec      (col_vec),
        .res_valid    (p1_valid_reg && p1_int_reg),
        .res_last     (p1_last_reg),
        .dilate_mode  (dilate_mode_reg),
        .element_mask (element_mask_reg),
        .red_valid    (red_valid),
        .red_beat     (red_beat)
    );

endmodule

`default_nettype wire

### hdl/rgbmorph_checker.sv
// Port-level checks for the morphology filter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rgbmorph_checker (
    input wire                                       aclk,
    input wire                                       aresetn,
    input wire                                       s_ready,
    input wire                                       m_valid,
    input wire                                       m_ready,
    input rgbmorph_pkg::out_beat_t                   m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled while output side is free");

endmodule

bind rgb_morph_erode_dilate_7x7 rgbmorph_checker u_rgbmorph_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the streaming 7x7 RGB erosion / dilation filter.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned FRAME_MAX  = 2048;
    localparam int unsigned WIN        = rgbmorph_pkg::MASK_SIDE;
    localparam int unsigned MASK_W     = rgbmorph_pkg::MASK_W;
    localparam int unsigned SIZE_W     = rgbmorph_pkg::SIZE_W;
    localparam int unsigned CFG_IDX_W  = rgbmorph_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = rgbmorph_pkg::CFG_DATA_W;
    localparam int unsigned ITEMS      = 850;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    rgbmorph_pkg::in_beat_t  s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    rgbmorph_pkg::out_beat_t m_data;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = rgbmorph_pkg::CFG_DILATE_MODE;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    logic              cfg_dilate = rgbmorph_pkg::RST_DILATE_MODE;
    logic [MASK_W-1:0] cfg_mask   = rgbmorph_pkg::RST_ELEMENT_MASK;
    logic [SIZE_W-1:0] cfg_width  = rgbmorph_pkg::RST_FRAME_WIDTH;
    logic [SIZE_W-1:0] cfg_height = rgbmorph_pkg::RST_FRAME_HEIGHT;

    bit [23:0]   line_mem [WIN-1][FRAME_MAX];
    bit [23:0]   win [WIN][WIN];
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;

    rgbmorph_pkg::out_beat_t filtered_q [$];
    rgbmorph_pkg::out_beat_t want;
    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int unsigned tx_idle_pct = 20;
    int unsigned rx_idle_pct = 46;

    rgb_morph_erode_dilate_7x7 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v);
        int unsigned d;
        d = 32'(v);
        if (d < WIN) return WIN;
        if (d > FRAME_MAX) return FRAME_MAX;
        return d;
    endfunction

    function automatic void compute_morph(input rgbmorph_pkg::in_beat_t b);
        bit [23:0]   column [WIN];
        bit [23:0]   v;
        logic [7:0]  acc [3];
        logic [7:0]  chan;
        int unsigned w, h, x;
        rgbmorph_pkg::out_beat_t res;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        if (b.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        x = (col_cnt < FRAME_MAX) ? col_cnt : FRAME_MAX - 1;
        column[WIN-1] = {b.red_in, b.green_in, b.blue_in};
        for (int k = 0; k < WIN - 1; k++) column[WIN-2-k] = line_mem[k][x];
        for (int k = WIN - 2; k > 0; k--) line_mem[k][x] = line_mem[k-1][x];
        line_mem[0][x] = column[WIN-1];
        for (int a = 0; a < WIN - 1; a++)
            for (int r = 0; r < WIN; r++) win[a][r] = win[a+1][r];
        for (int r = 0; r < WIN; r++) win[WIN-1][r] = column[r];

        if (col_cnt >= WIN - 1 && row_cnt >= WIN - 1 && col_cnt < w && row_cnt < h) begin
            for (int c = 0; c < 3; c++) begin
                acc[c] = cfg_dilate ? rgbmorph_pkg::DILATE_INIT : rgbmorph_pkg::ERODE_INIT;
            end
            for (int a = 0; a < WIN; a++) begin
                for (int r = 0; r < WIN; r++) begin
                    if (cfg_mask[a*WIN + r]) begin
                        v = win[a][r];
                        for (int c = 0; c < 3; c++) begin
                            chan = v[23 - 8*c -: 8];
                            if (cfg_dilate ? (chan > acc[c]) : (chan < acc[c])) acc[c] = chan;
                        end
                    end
                end
            end
            res.red_out    = acc[0];
            res.green_out  = acc[1];
            res.blue_out   = acc[2];
            res.frame_done = (col_cnt == w - 1 && row_cnt == h - 1);
            filtered_q.push_back(res);
        end

        if (col_cnt >= w - 1) begin
            col_cnt = 0;
            row_cnt = (row_cnt == h - 1) ? 0 : (row_cnt + 1) % (1 << rgbmorph_pkg::ROW_W);
        end else begin
            col_cnt++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_data);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                check_field("red_out", want.red_out, m_data.red_out);
                check_field("green_out", want.green_out, m_data.green_out);
                check_field("blue_out", want.blue_out, m_data.blue_out);
                check_field("frame_done", want.frame_done, m_data.frame_done);
            end
        end
    end

    function automatic logic [MASK_W-1:0] random_shape();
        logic [63:0] t;
        logic [63:0] u;
        t = {$urandom, $urandom};
        u = {$urandom, $urandom};
        case ($urandom_range(4))
            0: return '1;
            1: return '0;
            2: return 49'd1 << $urandom_range(MASK_W - 1);
            3: return t[MASK_W-1:0];
            default: return t[MASK_W-1:0] & u[MASK_W-1:0];
        endcase
    endfunction

    function automatic logic [7:0] pixel_value(input bit extremes);
        if (extremes && $urandom_range(2) != 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_beat(input rgbmorph_pkg::in_beat_t b);
        if (items_sent < ITEMS / 3) begin
            tx_idle_pct = 20;
            rx_idle_pct = 46;
        end else if (items_sent < 2 * ITEMS / 3) begin
            tx_idle_pct = 46;
            rx_idle_pct = 20;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        compute_morph(b);
        items_sent++;
    endtask

    task automatic send_run(input int unsigned n, input bit opening, input bit extremes,
                            input int unsigned restart_pm);
        rgbmorph_pkg::in_beat_t b;
        for (int unsigned i = 0; i < n; i++) begin
            b.frame_start = (i == 0 && opening) || ($urandom_range(999) < restart_pm);
            b.red_in      = pixel_value(extremes);
            b.green_in    = pixel_value(extremes);
            b.blue_in     = pixel_value(extremes);
            send_beat(b);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [MASK_W-1:0] shape,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= rgbmorph_pkg::CFG_DILATE_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_index <= rgbmorph_pkg::CFG_ELEMENT_MASK;
        cfg_wdata <= shape;
        @(posedge aclk);
        cfg_index <= rgbmorph_pkg::CFG_FRAME_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_index <= rgbmorph_pkg::CFG_FRAME_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_dilate = mode;
        cfg_mask   = shape;
        cfg_width  = w;
        cfg_height = h;
    endtask

    task automatic configure_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= rgbmorph_pkg::CFG_FRAME_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_index <= rgbmorph_pkg::CFG_FRAME_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
    endtask

    task automatic test_reset_config();
        configure_size(SIZE_W'(WIN), SIZE_W'(WIN));
        send_run(WIN * WIN, 1'b1, 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_shapes_and_modes();
        logic [MASK_W-1:0] shape;
        for (int m = 0; m < 2; m++) begin
            for (int k = 0; k < 3; k++) begin
                shape = (k == 0) ? '1 : (k == 1) ? '0 : random_shape();
                configure(m[0], shape, SIZE_W'(WIN), SIZE_W'(WIN));
                send_run(WIN * WIN, 1'b1, 1'b1, 0);
                wait_idle();
            end
        end
    endtask

    task automatic test_size_clamp_low();
        configure(1'b1, random_shape(), 12'd0, 12'd3);
        send_run(WIN * WIN, 1'b1, 1'b0, 0);
        send_run(WIN * WIN, 1'b0, 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_resize_midframe();
        configure(1'b0, '1, 12'd9, 12'd9);
        send_run(9 * 7 + 8, 1'b1, 1'b0, 0);
        wait_idle();
        configure(1'b0, '1, 12'd7, 12'd9);
        do send_run(1, 1'b0, 1'b0, 0); while (col_cnt != 0 || row_cnt != 0);
        wait_idle();
        configure(1'b1, random_shape(), 12'd7, 12'd9);
        send_run(7 * 7, 1'b1, 1'b0, 0);
        wait_idle();
        configure(1'b1, cfg_mask, 12'd7, 12'd7);
        send_run(14, 1'b0, 1'b0, 0);
        send_run(7 * 7, 1'b1, 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_frame_restart();
        configure(1'b1, random_shape(), 12'd8, 12'd7);
        send_run(30, 1'b1, 1'b0, 0);
        send_run(8 * 7, 1'b1, 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        logic [SIZE_W-1:0] w_reg;
        logic [SIZE_W-1:0] h_reg;
        bit opening;
        while (items_sent < ITEMS) begin
            w_reg = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(WIN - 1))
                                             : SIZE_W'($urandom_range(WIN, 20));
            h_reg = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(WIN - 1))
                                             : SIZE_W'($urandom_range(WIN, 16));
            configure(1'($urandom_range(1)), random_shape(), w_reg, h_reg);
            w = clamp_dim(w_reg);
            h = clamp_dim(h_reg);
            opening = (col_cnt != 0 || row_cnt != 0) || ($urandom_range(3) != 0);
            send_run(w * h, opening, 1'($urandom_range(1)), ($urandom_range(4) == 0) ? 8 : 0);
            wait_idle();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_shapes_and_modes();
        test_size_clamp_low();
        test_resize_midframe();
        test_frame_restart();
        test_random_frames();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
